### hdl/hbud_pkg.sv
package hbud_pkg;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 10;

	localparam logic [CFG_AW-1:0] REG_MTU_LEN       = 2'd0;
	localparam logic [CFG_AW-1:0] REG_FLAG_BYTE     = 2'd1;
	localparam logic [CFG_AW-1:0] REG_ESCAPE_BYTE   = 2'd2;
	localparam logic [CFG_AW-1:0] REG_ESCAPE_MASK   = 2'd3;

	localparam logic [9:0] RST_MTU_LEN       = 10'd500;
	localparam logic [7:0] RST_FLAG_BYTE     = 8'd126;
	localparam logic [7:0] RST_ESCAPE_BYTE   = 8'd125;
	localparam logic [7:0] RST_ESCAPE_MASK   = 8'd32;

	localparam logic [1:0] EV_DATA    = 2'd0;
	localparam logic [1:0] EV_ACCEPT  = 2'd1;
	localparam logic [1:0] EV_DISCARD = 2'd2;

	typedef struct packed {
		logic [9:0] mtu_len;
		logic [7:0] flag_byte;
		logic [7:0] escape_byte;
		logic [7:0] escape_mask;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] event_res;
		logic [9:0] frm_len;
	} res_t;

endpackage

### hdl/hbud_cfg.sv
module hbud_cfg
	import hbud_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [CFG_AW-1:0] addr,
	input  logic [CFG_DW-1:0] wdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mtu_len       <= RST_MTU_LEN;
			cfg_q.flag_byte     <= RST_FLAG_BYTE;
			cfg_q.escape_byte   <= RST_ESCAPE_BYTE;
			cfg_q.escape_mask   <= RST_ESCAPE_MASK;
		end else if (we) begin
			case (addr)
				REG_MTU_LEN:       cfg_q.mtu_len       <= wdata[9:0];
				REG_FLAG_BYTE:     cfg_q.flag_byte     <= wdata[7:0];
				REG_ESCAPE_BYTE:   cfg_q.escape_byte   <= wdata[7:0];
				REG_ESCAPE_MASK:   cfg_q.escape_mask   <= wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/hbud_core.sv
module hbud_core
	import hbud_pkg::*;
#(
	parameter int FRAME_CAP = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output logic       res_valid,
	output res_t       res
);

	localparam int CW = $clog2(FRAME_CAP + 1);
	localparam int LW = (CW > 10) ? CW : 10;

	logic          in_frame_q;
	logic          esc_pending_q;
	logic [CW-1:0] count_q;

	logic          in_frame_d;
	logic          esc_pending_d;
	logic [CW-1:0] count_d;

	logic          is_flag;
	logic          is_esc;
	logic [7:0]    data_byte;
	logic          at_cap;
	logic          len_ok;

	assign is_flag   = (rx_byte == cfg.flag_byte);
	assign is_esc    = (rx_byte == cfg.escape_byte);
	assign data_byte = esc_pending_q ? (rx_byte ^ cfg.escape_mask) : rx_byte;
	assign at_cap    = (count_q >= CW'(FRAME_CAP));
	assign len_ok    = (LW'(count_q) <= LW'(cfg.mtu_len));

	always_comb begin
		in_frame_d    = in_frame_q;
		esc_pending_d = esc_pending_q;
		count_d       = count_q;
		res_valid     = 1'b0;
		res.out_byte  = 8'd0;
		res.event_res = EV_DATA;
		res.frm_len   = 10'd0;
		if (is_flag) begin
			if (in_frame_q && (count_q != '0)) begin
				res_valid     = 1'b1;
				res.event_res = len_ok ? EV_ACCEPT : EV_DISCARD;
				res.frm_len   = 10'(count_q);
			end
			in_frame_d    = 1'b1;
			esc_pending_d = 1'b0;
			count_d       = '0;
		end else if (in_frame_q) begin
			if (is_esc) begin
				esc_pending_d = 1'b1;
			end else if (at_cap) begin
				res_valid     = 1'b1;
				res.event_res = EV_DISCARD;
				res.frm_len   = 10'(count_q);
				in_frame_d    = 1'b0;
				esc_pending_d = 1'b0;
				count_d       = '0;
			end else begin
				res_valid     = 1'b1;
				res.out_byte  = data_byte;
				esc_pending_d = 1'b0;
				count_d       = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			esc_pending_q <= 1'b0;
			count_q       <= '0;
		end else if (en) begin
			in_frame_q    <= in_frame_d;
			esc_pending_q <= esc_pending_d;
			count_q       <= count_d;
		end
	end

endmodule

### hdl/hdlc_byte_unstuff_deframer.sv
// hdlc byte-stuffing deframer
// s_axis carries one raw received byte per beat in tdata[7:0].
// m_axis carries one event per beat: tdata[7:0] unstuffed byte, tdata[17:8]
// frame length, tuser[1:0] event (data, frame accepted, frame discarded).
// data events carry a zero length, end and discard events a zero byte.
// escape bytes, bytes outside a frame and flag bytes that close no non-empty frame produce no beat.
// cfg port: cfg_we writes cfg_wdata into register cfg_addr
// (0 max frame length, 1 flag, 2 escape, 3 escape mask); write only when idle.
// pipeline: two register stages; an event passes from the input register
// through the frame logic into the output register before it is valid on m_axis.
// throughput: one byte per cycle while m_axis is not stalled; the frame
// state (in-frame, escape pending, byte count) is updated between the
// input register and the output register.
// a stalled m_axis holds its beat; one more byte is taken into the input
// register, then s_axis_tready drops until the output beat is taken.
// reset clears the frame state and loads the register defaults
// (500, 0x7e, 0x7d, 0x20); no clearing pass is needed.
module hdlc_byte_unstuff_deframer
	import hbud_pkg::*;
#(
	parameter int FRAME_CAP = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,  // rx_byte
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [23:0]       m_axis_tdata,  // out_byte, frm_len, zero fill
	output logic [1:0]        m_axis_tuser,  // event_res
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       res_valid;
	res_t       res;
	logic       out_valid_q;
	res_t       out_q;

	hbud_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.addr  (cfg_addr),
		.wdata (cfg_wdata),
		.cfg   (cfg)
	);

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	hbud_core #(
		.FRAME_CAP(FRAME_CAP)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (valid_s1 && adv),
		.rx_byte  (byte_s1),
		.cfg      (cfg),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_q.frm_len, out_q.out_byte};
	assign m_axis_tuser  = out_q.event_res;

endmodule
